[src/lmcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load meter calibration control package
// Shared types, codes and arithmetic constants for the controller and the
// datapath of the load meter calibration block.
// ----------------------------------------------------------------------------
package lmcc_pkg;

	// Default converter width.
	localparam int SAMPLE_BITS_DEF = 12;

	// Field widths.
	localparam int KEY_W    = 3;
	localparam int MODE_W   = 2;
	localparam int DUTY_W   = 8;
	localparam int GAIN_W   = 16;
	localparam int RESULT_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q12   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT = 2'd1;

	// Configuration reset values.
	localparam logic [GAIN_W-1:0] GAIN_RESET       = 16'd4096;
	localparam logic [DUTY_W-1:0] DUTY_LIMIT_RESET = 8'd84;

	// Scale factors: volts use 5.0 * 5.7143 * 100 over 4096 (both scaled up by
	// 100), amps use 5.0 * 100 over 4096.
	localparam int K_W = 19;
	localparam logic [K_W-1:0] VOLT_NUM_K = 19'd285715;
	localparam logic [K_W-1:0] VOLT_DEN_K = 19'd409600;
	localparam logic [K_W-1:0] AMP_NUM_K  = 19'd500;
	localparam logic [K_W-1:0] AMP_DEN_K  = 19'd4096;

	// The divider produces one more quotient bit than the result so that an
	// overflow can be seen and saturated.
	localparam int QUO_W     = RESULT_W + 1;
	localparam int DIV_STEPS = QUO_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// Key events.
	typedef enum logic [KEY_W-1:0] {
		KEY_NONE  = 3'd0,
		KEY_OK    = 3'd1,
		KEY_UP    = 3'd2,
		KEY_DOWN  = 3'd3,
		KEY_LEFT  = 3'd4,
		KEY_RIGHT = 3'd5
	} key_t;

	// Operating modes.
	typedef enum logic [MODE_W-1:0] {
		MODE_RUN = 2'd0,
		MODE_OFS = 2'd1,
		MODE_FS  = 2'd2
	} mode_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_MUL1 = 3'd1,
		ST_MUL2 = 3'd2,
		ST_DIV  = 3'd3,
		ST_DONE = 3'd4
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic div_step;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic run;
	} sts_t;

endpackage

[src/lmcc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load meter calibration controller
// Sequences one step: accept, the two multiply states, the divide iterations
// and the output hand-off; a calibration beat goes from accept to the hand-off.
// ----------------------------------------------------------------------------
module lmcc_ctrl
	import lmcc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic [STEP_W-1:0] step_q;
	logic out_valid_q;
	logic out_free;
	logic div_last;

	// The output register can take a beat when empty or when it drains now.
	assign out_free = !out_valid_q || !out_stall;
	assign div_last = (step_q == STEP_W'(DIV_STEPS - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.run ? ST_MUL1 : ST_DONE;
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_DIV;
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and commands.
	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_MUL1: cmd.mul1 = 1'b1;
			ST_MUL2: cmd.mul2 = 1'b1;
			ST_DIV:  cmd.div_step = 1'b1;
			ST_DONE: cmd.finish = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	assign out_valid = out_valid_q;

	// State, divide step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) begin
				step_q <= div_last ? '0 : step_q + 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A run-mode beat goes through the multipliers.
	a_run_measures: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && sts.run |=> state_q == ST_MUL1)
		else $error("run-mode beat did not start a measurement");

	// A calibration-mode beat goes straight to the output hand-off.
	a_cal_skips: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !sts.run |=> state_q == ST_DONE)
		else $error("calibration beat did not skip the measurement");

	// A finished result waits while the previous beat is still held.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_valid_q && out_stall |=> state_q == ST_DONE)
		else $error("result written over a stalled output beat");

endmodule

[src/lmcc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load meter calibration datapath
// Holds mode, duty, calibration and configuration registers, and two lanes
// (volts, amps) of multiply and restoring divide.
// ----------------------------------------------------------------------------
module lmcc_datapath
	import lmcc_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output sts_t sts,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [KEY_W-1:0] key,
	input  logic [SAMPLE_BITS-1:0] volt_sample,
	input  logic [SAMPLE_BITS-1:0] amp_sample,
	output logic [MODE_W-1:0] mode,
	output logic [DUTY_W-1:0] duty_step,
	output logic [RESULT_W-1:0] volt_centi,
	output logic [RESULT_W-1:0] amp_centi
);

	localparam int LANES = 2;
	localparam int P_W   = SAMPLE_BITS + K_W;
	localparam int N_W   = P_W + GAIN_W;
	localparam int DEN_W = K_W + SAMPLE_BITS;
	localparam logic [K_W-1:0] NUM_K [LANES] = '{VOLT_NUM_K, AMP_NUM_K};
	localparam logic [K_W-1:0] DEN_K [LANES] = '{VOLT_DEN_K, AMP_DEN_K};

	logic [GAIN_W-1:0] gain_q;
	logic [DUTY_W-1:0] limit_q;
	mode_t mode_q;
	logic [DUTY_W-1:0] duty_q;
	logic [SAMPLE_BITS-1:0] offset_q;
	logic [SAMPLE_BITS-1:0] fs_q;
	logic meas_q;
	mode_t out_mode_q;
	logic [DUTY_W-1:0] out_duty_q;
	logic [RESULT_W-1:0] volt_held_q;
	logic [RESULT_W-1:0] amp_held_q;

	logic [SAMPLE_BITS-1:0] sample [LANES];
	logic [SAMPLE_BITS-1:0] d_q [LANES];
	logic [P_W-1:0] p1_q [LANES];
	logic [DEN_W-1:0] den_q [LANES];
	logic [N_W-1:0] rem_q [LANES];
	logic [N_W-1:0] dvs_q [LANES];
	logic [QUO_W-1:0] quo_q [LANES];
	logic [RESULT_W-1:0] res [LANES];

	key_t key_in;
	mode_t mode_d;
	logic [DUTY_W-1:0] duty_d;

	assign key_in = key_t'(key);
	assign sample[0] = volt_sample;
	assign sample[1] = amp_sample;

	// Mode code three is never reached and counts as run.
	assign sts.run = (mode_q != MODE_OFS) && (mode_q != MODE_FS);

	// Key handling for the run mode.
	always_comb begin
		mode_d = MODE_RUN;
		duty_d = duty_q;
		case (key_in)
			KEY_OK:   mode_d = MODE_OFS;
			KEY_UP:   duty_d = (duty_q >= limit_q) ? '0 : duty_q + 1'b1;
			KEY_DOWN: duty_d = (duty_q == '0) ? limit_q : duty_q - 1'b1;
			default:  duty_d = duty_q;
		endcase
	end

	// Control registers: configuration, mode, duty and calibration points.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			limit_q <= DUTY_LIMIT_RESET;
			mode_q <= MODE_RUN;
			duty_q <= '0;
			offset_q <= '0;
			fs_q <= '1;
			meas_q <= 1'b0;
			out_mode_q <= MODE_RUN;
			out_duty_q <= '0;
			volt_held_q <= '0;
			amp_held_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_GAIN_Q12:   gain_q <= cfg_data[GAIN_W-1:0];
					CFG_DUTY_LIMIT: limit_q <= cfg_data[DUTY_W-1:0];
					default:        gain_q <= gain_q;
				endcase
			end
			if (cmd.load) begin
				meas_q <= sts.run;
				case (mode_q)
					MODE_OFS: begin
						if (key_in == KEY_LEFT) begin
							offset_q <= volt_sample;
							mode_q <= MODE_FS;
						end else if (key_in == KEY_RIGHT) begin
							mode_q <= MODE_RUN;
						end
					end
					MODE_FS: begin
						if (key_in == KEY_LEFT) begin
							fs_q <= volt_sample;
							mode_q <= MODE_RUN;
						end
					end
					default: begin
						mode_q <= mode_d;
						duty_q <= duty_d;
					end
				endcase
			end
			if (cmd.finish) begin
				out_mode_q <= mode_q;
				out_duty_q <= duty_q;
				if (meas_q) begin
					volt_held_q <= res[0];
					amp_held_q <= res[1];
				end
			end
		end
	end

	// Saturate on an overflow quotient bit. A zero full scale makes every
	// divide step succeed, so it saturates as well.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			res[i] = quo_q[i][QUO_W-1] ? '1 : quo_q[i][RESULT_W-1:0];
		end
	end

	// Measurement lanes: offset removal, two multiplies, restoring divide.
	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			if (cmd.load) begin
				d_q[i] <= (sample[i] > offset_q) ? sample[i] - offset_q : '0;
			end
			if (cmd.mul1) begin
				p1_q[i] <= P_W'(d_q[i]) * P_W'(NUM_K[i]);
				den_q[i] <= DEN_W'(DEN_K[i]) * DEN_W'(fs_q);
			end
			if (cmd.mul2) begin
				rem_q[i] <= N_W'(p1_q[i]) * N_W'(gain_q);
				dvs_q[i] <= {den_q[i], {RESULT_W{1'b0}}};
				quo_q[i] <= '0;
			end
			if (cmd.div_step) begin
				if (rem_q[i] >= dvs_q[i]) begin
					rem_q[i] <= rem_q[i] - dvs_q[i];
					quo_q[i] <= {quo_q[i][QUO_W-2:0], 1'b1};
				end else begin
					quo_q[i] <= {quo_q[i][QUO_W-2:0], 1'b0};
				end
				dvs_q[i] <= dvs_q[i] >> 1;
			end
		end
	end

	assign mode = out_mode_q;
	assign duty_step = out_duty_q;
	assign volt_centi = volt_held_q;
	assign amp_centi = amp_held_q;

	// A zero full scale reads as full range on both channels.
	a_zero_fs_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && meas_q && fs_q == '0 |=> volt_held_q == '1 && amp_held_q == '1)
		else $error("zero full scale did not saturate");

	// Calibration points stay put while a measurement is running.
	a_cal_stable: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul1 || cmd.mul2 || cmd.div_step |=> $stable(offset_q) && $stable(fs_q))
		else $error("calibration changed during a measurement");

	// Held measurements change only at the output hand-off.
	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.finish |=> $stable(volt_held_q) && $stable(amp_held_q))
		else $error("held measurement changed outside the hand-off");

endmodule

[src/load_meter_calibration_control.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load meter calibration control
// One front-panel step of an electronic load: key handling, PWM duty,
// offset and full-scale calibration, and scaled volt and amp readings.
//
// Usage: each input beat (in_valid, in_stall) carries a key and one sample
// per channel; each beat gives exactly one output beat (out_valid,
// out_stall) with the mode, duty step and last measured values.
// In run mode a beat goes from accept through the two multiplies, then
// 17 restoring divide iterations, both channels in parallel lanes, then
// the output hand-off. In calibration modes a beat goes straight from
// accept to the hand-off. The next beat is accepted the cycle after the
// hand-off, so a beat is only taken once the one before it is handed off.
// A new beat is accepted while the previous result still waits in the output
// register; a stalled receiver holds that result and the block stops before
// its next hand-off. Configuration writes take effect at once and belong
// to idle periods. Reset restores run mode, duty 0, offset 0, full scale at
// maximum, zero readings, gain 1.0 and a duty limit of 84.
// ----------------------------------------------------------------------------
module load_meter_calibration_control
	import lmcc_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [KEY_W-1:0] key,
	input  logic [SAMPLE_BITS-1:0] volt_sample,
	input  logic [SAMPLE_BITS-1:0] amp_sample,
	output logic out_valid,
	input  logic out_stall,
	output logic [MODE_W-1:0] mode,
	output logic [DUTY_W-1:0] duty_step,
	output logic [RESULT_W-1:0] volt_centi,
	output logic [RESULT_W-1:0] amp_centi
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	lmcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Registers and arithmetic.
	lmcc_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.key         (key),
		.volt_sample (volt_sample),
		.amp_sample  (amp_sample),
		.mode        (mode),
		.duty_step   (duty_step),
		.volt_centi  (volt_centi),
		.amp_centi   (amp_centi)
	);

endmodule

[dv/lmcc_reading_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load meter reading checker
// Watches the configuration port and both beat channels of the load meter
// calibration block. It keeps its own copy of the panel state, works out the
// reading that each accepted input beat must produce, and compares every
// accepted output beat field by field with the oldest reading still due.
// ----------------------------------------------------------------------------
module lmcc_reading_checker
	import lmcc_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	input  logic in_stall,
	input  logic [KEY_W-1:0] key,
	input  logic [SAMPLE_BITS-1:0] volt_sample,
	input  logic [SAMPLE_BITS-1:0] amp_sample,
	input  logic out_valid,
	input  logic out_stall,
	input  logic [MODE_W-1:0] mode,
	input  logic [DUTY_W-1:0] duty_step,
	input  logic [RESULT_W-1:0] volt_centi,
	input  logic [RESULT_W-1:0] amp_centi,
	output int errors,
	output int pending
);

	// Volts scale by 5.0 * 5.7143 * 100, amps by 5.0 * 100; both over 4096
	// for the gain. The volt factor carries two extra decimal digits.
	localparam longint unsigned VOLT_NUM = 285715;
	localparam longint unsigned VOLT_DEN = 409600;
	localparam longint unsigned AMP_NUM  = 500;
	localparam longint unsigned AMP_DEN  = 4096;
	localparam logic [RESULT_W-1:0] READING_MAX = '1;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [DUTY_W-1:0]   duty;
		logic [RESULT_W-1:0] volt;
		logic [RESULT_W-1:0] amp;
	} panel_reading_t;

	// Shadow copy of the configuration and of the panel state.
	logic [GAIN_W-1:0] gain;
	logic [DUTY_W-1:0] duty_limit;
	mode_t panel_mode;
	logic [DUTY_W-1:0] duty;
	logic [SAMPLE_BITS-1:0] offset;
	logic [SAMPLE_BITS-1:0] full_scale;
	logic [RESULT_W-1:0] volt_held;
	logic [RESULT_W-1:0] amp_held;

	panel_reading_t readings_due[$];
	panel_reading_t due_reading;
	int fault_count;

	// Offset-corrected sample, scaled and saturated to the result width.
	// A zero full scale pins the reading at its maximum.
	function automatic logic [RESULT_W-1:0] scale_reading(
		input logic [SAMPLE_BITS-1:0] sample,
		input longint unsigned num_k,
		input longint unsigned den_k
	);
		longint unsigned diff;
		longint unsigned quo;
		if (full_scale == '0)
			return READING_MAX;
		diff = 0;
		if (sample > offset)
			diff = longint'(sample - offset);
		quo = (diff * num_k * longint'(gain)) / (den_k * longint'(full_scale));
		return (quo > longint'(READING_MAX)) ? READING_MAX : quo[RESULT_W-1:0];
	endfunction

	// Apply one key step to the panel state and return the reading it shows.
	// Run mode measures with the offset and full scale from before the key.
	function automatic panel_reading_t step_panel(
		input logic [KEY_W-1:0] k,
		input logic [SAMPLE_BITS-1:0] vsamp,
		input logic [SAMPLE_BITS-1:0] asamp
	);
		panel_reading_t r;
		if (panel_mode == MODE_OFS) begin
			if (k == KEY_LEFT) begin
				offset = vsamp;
				panel_mode = MODE_FS;
			end else if (k == KEY_RIGHT) begin
				panel_mode = MODE_RUN;
			end
		end else if (panel_mode == MODE_FS) begin
			if (k == KEY_LEFT) begin
				full_scale = vsamp;
				panel_mode = MODE_RUN;
			end
		end else begin
			volt_held = scale_reading(vsamp, VOLT_NUM, VOLT_DEN);
			amp_held = scale_reading(asamp, AMP_NUM, AMP_DEN);
			panel_mode = MODE_RUN;
			case (k)
				KEY_OK: begin
					panel_mode = MODE_OFS;
				end
				KEY_UP: begin
					duty = (duty >= duty_limit) ? '0 : duty + 1'b1;
				end
				KEY_DOWN: begin
					duty = (duty == '0) ? duty_limit : duty - 1'b1;
				end
				default: begin
				end
			endcase
		end
		r.mode = panel_mode;
		r.duty = duty;
		r.volt = volt_held;
		r.amp = amp_held;
		return r;
	endfunction

	// Compare finished beats first, then record the reading for a new one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain = GAIN_RESET;
			duty_limit = DUTY_LIMIT_RESET;
			panel_mode = MODE_RUN;
			duty = '0;
			offset = '0;
			full_scale = '1;
			volt_held = '0;
			amp_held = '0;
			readings_due.delete();
			fault_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (readings_due.size() == 0) begin
					$error("result beat with no reading due: mode %0d duty %0d volt %0d amp %0d",
						mode, duty_step, volt_centi, amp_centi);
					fault_count++;
				end else begin
					due_reading = readings_due.pop_front();
					if (mode !== due_reading.mode) begin
						$error("mode: expected %0d, got %0d", due_reading.mode, mode);
						fault_count++;
					end
					if (duty_step !== due_reading.duty) begin
						$error("duty_step: expected %0d, got %0d", due_reading.duty, duty_step);
						fault_count++;
					end
					if (volt_centi !== due_reading.volt) begin
						$error("volt_centi: expected %0d, got %0d", due_reading.volt, volt_centi);
						fault_count++;
					end
					if (amp_centi !== due_reading.amp) begin
						$error("amp_centi: expected %0d, got %0d", due_reading.amp, amp_centi);
						fault_count++;
					end
				end
			end

			// Register writes; unused indexes fall through untouched.
			if (cfg_we) begin
				if (cfg_index == CFG_GAIN_Q12)
					gain = cfg_data[GAIN_W-1:0];
				else if (cfg_index == CFG_DUTY_LIMIT)
					duty_limit = cfg_data[DUTY_W-1:0];
			end

			if (in_valid && !in_stall)
				readings_due.push_back(step_panel(key, volt_sample, amp_sample));

			errors <= fault_count;
			pending <= readings_due.size();
		end
	end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load meter calibration control testbench
// Drives key and sample beats into the block: a directed walk through the
// duty wrap, ignored keys and both calibration captures, then phases of
// random run-mode traffic and calibration sequences under varying gain and
// duty limits, with random gaps on the sender and stalls on the receiver.
// A separate checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import lmcc_pkg::*;

	localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASES = 15;
	localparam int PHASE_ITEMS = 105;
	localparam int CFG_PAD_W = CFG_DATA_W - DUTY_W;

	// Key codes with no meaning in any mode, and register indexes with no
	// register behind them.
	localparam logic [KEY_W-1:0] KEY_SPARE6 = 3'd6;
	localparam logic [KEY_W-1:0] KEY_SPARE7 = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [KEY_W-1:0] key = '0;
	logic [SAMPLE_BITS-1:0] volt_sample = '0;
	logic [SAMPLE_BITS-1:0] amp_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [MODE_W-1:0] mode;
	logic [DUTY_W-1:0] duty_step;
	logic [RESULT_W-1:0] volt_centi;
	logic [RESULT_W-1:0] amp_centi;

	int errors;
	int pending;
	int cycle_count = 0;
	bit quiet = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	load_meter_calibration_control #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.key(key),
		.volt_sample(volt_sample),
		.amp_sample(amp_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mode(mode),
		.duty_step(duty_step),
		.volt_centi(volt_centi),
		.amp_centi(amp_centi)
	);

	lmcc_reading_checker #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) reading_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.key(key),
		.volt_sample(volt_sample),
		.amp_sample(amp_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mode(mode),
		.duty_step(duty_step),
		.volt_centi(volt_centi),
		.amp_centi(amp_centi),
		.errors(errors),
		.pending(pending)
	);

	// Idle lengths: mostly none or short, now and then long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Samples lean toward the rails now and then.
	function automatic logic [SAMPLE_BITS-1:0] any_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return SAMPLE_MAX;
		return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
	endfunction

	// Run-mode keys; ok is left to the calibration sequences.
	function automatic logic [KEY_W-1:0] run_key(input int up_bias);
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return KEY_NONE;
		if (r < 20 + up_bias)
			return KEY_UP;
		if (r < 82)
			return KEY_DOWN;
		case ($urandom_range(0, 3))
			0: return KEY_LEFT;
			1: return KEY_RIGHT;
			2: return KEY_SPARE6;
			default: return KEY_SPARE7;
		endcase
	endfunction

	// Keys that a calibration mode ignores; right only where it is ignored too.
	function automatic logic [KEY_W-1:0] cal_noise_key(input bit allow_right);
		case ($urandom_range(0, allow_right ? 6 : 5))
			0: return KEY_NONE;
			1: return KEY_UP;
			2: return KEY_DOWN;
			3: return KEY_OK;
			4: return KEY_SPARE6;
			5: return KEY_SPARE7;
			default: return KEY_RIGHT;
		endcase
	endfunction

	// Present one beat, hold it until accepted, then maybe go idle a while.
	task automatic send_beat(
		input logic [KEY_W-1:0] k,
		input logic [SAMPLE_BITS-1:0] v,
		input logic [SAMPLE_BITS-1:0] a
	);
		int g;
		in_valid <= 1'b1;
		key <= k;
		volt_sample <= v;
		amp_sample <= a;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		g = quiet ? 0 : gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every reading due has come out.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(
		input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data
	);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Write a spare index, then reprogram both registers in random order, once the block is idle.
	task automatic configure(input logic [GAIN_W-1:0] g, input logic [DUTY_W-1:0] lim);
		settle();
		write_reg($urandom_range(0, 1) ? CFG_SPARE2 : CFG_SPARE3, CFG_DATA_W'($urandom()));
		if ($urandom_range(0, 1)) begin
			write_reg(CFG_GAIN_Q12, g);
			write_reg(CFG_DUTY_LIMIT, {CFG_PAD_W'($urandom()), lim});
		end else begin
			write_reg(CFG_DUTY_LIMIT, {CFG_PAD_W'($urandom()), lim});
			write_reg(CFG_GAIN_Q12, g);
		end
		cfg_we <= 1'b0;
	endtask

	// Enter offset calibration, capture an offset, then a full scale, with
	// ignored keys in between; sometimes abandoned with right.
	task automatic calibrate(output int sent);
		int n;
		int r;
		logic [SAMPLE_BITS-1:0] level;
		sent = 0;
		send_beat(KEY_OK, any_sample(), any_sample());
		sent++;
		n = $urandom_range(0, 2);
		repeat (n) begin
			send_beat(cal_noise_key(1'b0), any_sample(), any_sample());
			sent++;
		end
		if ($urandom_range(0, 6) == 0) begin
			send_beat(KEY_RIGHT, any_sample(), any_sample());
			sent++;
			return;
		end

		r = $urandom_range(0, 9);
		if (r < 7)
			level = SAMPLE_BITS'($urandom_range(0, 400));
		else if (r == 7)
			level = '0;
		else
			level = any_sample();
		send_beat(KEY_LEFT, level, any_sample());
		sent++;

		n = $urandom_range(0, 2);
		repeat (n) begin
			send_beat(cal_noise_key(1'b1), any_sample(), any_sample());
			sent++;
		end

		r = $urandom_range(0, 19);
		if (r < 14)
			level = SAMPLE_BITS'($urandom_range(2500, (1 << SAMPLE_BITS) - 1));
		else if (r < 16)
			level = SAMPLE_MAX;
		else if (r < 18)
			level = any_sample();
		else if (r == 18)
			level = '0;
		else
			level = SAMPLE_BITS'($urandom_range(1, 50));
		send_beat(KEY_LEFT, level, any_sample());
		sent++;
	endtask

	task automatic run_phase(input int n_items, input int up_bias);
		int done;
		int k;
		done = 0;
		while (done < n_items) begin
			if ($urandom_range(0, 99) < 8) begin
				calibrate(k);
				done += k;
			end else begin
				send_beat(run_key(up_bias), any_sample(), any_sample());
				done++;
			end
		end
	endtask

	// Receiver stalls: a ready stretch, then a stall burst of random length.
	initial begin
		int ready_len;
		int stall_len;
		@(posedge arst_n);
		forever begin
			if (quiet) begin
				@(posedge clk);
				out_stall <= 1'b0;
			end else begin
				ready_len = $urandom_range(1, 24);
				repeat (ready_len) begin
					@(posedge clk);
					out_stall <= 1'b0;
				end
				stall_len = gap_len();
				repeat (stall_len) begin
					@(posedge clk);
					out_stall <= 1'b1;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("[load_meter_calibration_control] ERROR");
		$finish;
	end

	initial begin
		int phase;
		int bias;
		logic [GAIN_W-1:0] g;
		logic [DUTY_W-1:0] lim;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk with the reset configuration.
		send_beat(KEY_NONE, '0, '0);
		send_beat(KEY_NONE, SAMPLE_MAX, SAMPLE_MAX);
		send_beat(KEY_DOWN, SAMPLE_BITS'(2048), SAMPLE_BITS'(1));   // wraps up to the limit
		send_beat(KEY_UP, SAMPLE_BITS'(1), SAMPLE_BITS'(2048));     // wraps back to zero
		send_beat(KEY_UP, SAMPLE_BITS'(1000), SAMPLE_BITS'(3000));
		send_beat(KEY_DOWN, SAMPLE_BITS'(3000), SAMPLE_BITS'(1000));
		send_beat(KEY_SPARE6, SAMPLE_MAX, '0);
		send_beat(KEY_SPARE7, '0, SAMPLE_MAX);
		send_beat(KEY_LEFT, SAMPLE_BITS'(77), SAMPLE_BITS'(99));
		send_beat(KEY_RIGHT, SAMPLE_BITS'(99), SAMPLE_BITS'(77));
		// Ok still measures with the old calibration.
		send_beat(KEY_OK, SAMPLE_BITS'(2500), SAMPLE_BITS'(1500));
		send_beat(KEY_UP, SAMPLE_BITS'(5), SAMPLE_BITS'(5));
		send_beat(KEY_SPARE7, SAMPLE_BITS'(6), SAMPLE_BITS'(6));
		send_beat(KEY_RIGHT, SAMPLE_BITS'(7), SAMPLE_BITS'(7));
		send_beat(KEY_OK, SAMPLE_BITS'(8), SAMPLE_BITS'(8));
		send_beat(KEY_LEFT, SAMPLE_BITS'(100), SAMPLE_BITS'(9));
		send_beat(KEY_RIGHT, SAMPLE_BITS'(10), SAMPLE_BITS'(10));
		send_beat(KEY_OK, SAMPLE_BITS'(11), SAMPLE_BITS'(11));
		// A zero full scale pins both readings at the top.
		send_beat(KEY_LEFT, '0, SAMPLE_BITS'(12));
		send_beat(KEY_NONE, SAMPLE_BITS'(1234), SAMPLE_BITS'(50));
		// Full scale of one with no offset saturates.
		send_beat(KEY_OK, SAMPLE_BITS'(13), SAMPLE_BITS'(13));
		send_beat(KEY_LEFT, '0, SAMPLE_BITS'(14));
		send_beat(KEY_LEFT, SAMPLE_BITS'(1), SAMPLE_BITS'(15));
		send_beat(KEY_NONE, SAMPLE_MAX, SAMPLE_MAX);
		// A sample below the offset floors at zero.
		send_beat(KEY_OK, SAMPLE_BITS'(16), SAMPLE_BITS'(16));
		send_beat(KEY_LEFT, SAMPLE_BITS'(2000), SAMPLE_BITS'(17));
		send_beat(KEY_LEFT, SAMPLE_MAX, SAMPLE_BITS'(18));
		send_beat(KEY_NONE, SAMPLE_BITS'(10), SAMPLE_BITS'(3000));

		// Random phases. The first few pin the register extremes: a high
		// limit lets the duty climb, the low limits after it leave the duty
		// above the limit and then at a zero limit.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					g = '1;
					lim = '1;
					bias = 55;
				end
				1: begin
					g = GAIN_W'(1);
					lim = DUTY_W'(1);
					bias = 35;
				end
				2: begin
					g = '0;
					lim = '0;
					bias = 35;
				end
				3: begin
					g = GAIN_RESET;
					lim = DUTY_LIMIT_RESET;
					bias = 40;
				end
				default: begin
					case ($urandom_range(0, 4))
						0: g = '1;
						1: g = '0;
						2: g = GAIN_W'($urandom());
						default: g = GAIN_W'($urandom_range(2048, 8191));
					endcase
					case ($urandom_range(0, 4))
						0: lim = '0;
						1: lim = '1;
						2: lim = DUTY_W'(1);
						default: lim = DUTY_W'($urandom_range(2, 120));
					endcase
					bias = $urandom_range(25, 45);
				end
			endcase
			quiet = (phase == 3) || ($urandom_range(0, 4) == 0);
			configure(g, lim);
			run_phase(PHASE_ITEMS, bias);
		end

		settle();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[load_meter_calibration_control] OK");
		else
			$display("[load_meter_calibration_control] ERROR");
		$finish;
	end

endmodule
